>>> rtl/assert_macros.svh
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLKRST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Same, on the usual clk_i / rst_ni pair.
`define ASSERT_DFLT(lbl, prop, msg) `ASSERT_CLKRST(lbl, clk_i, rst_ni, prop, msg)

`endif

>>> rtl/pls_pkg.sv
package pls_pkg;

  localparam int unsigned CMD_W    = 4;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned FOUND_W  = 5;
  localparam int unsigned RDVAL_W  = 32;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FIRST = 4'd0,
    CMD_INS_LAST  = 4'd1,
    CMD_INS_AT    = 4'd2,
    CMD_DEL_FIRST = 4'd3,
    CMD_DEL_LAST  = 4'd4,
    CMD_DEL_AT    = 4'd5,
    CMD_SEARCH    = 4'd6,
    CMD_SORT      = 4'd7,
    CMD_READ_AT   = 4'd8
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SHIFT_UP,
    S_PUT,
    S_SHIFT_DN,
    S_SEARCH,
    S_READ,
    S_SORT_LOAD,
    S_SORT_STEP,
    S_SORT_END,
    S_DONE
  } state_e;

  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_res_t;

  typedef struct packed {
    status_e              status;
    logic [FOUND_W-1:0]   found_index;
    logic [RDVAL_W-1:0]   read_value;
    logic [COUNT_W-1:0]   entry_count;
  } res_t;

endpackage

>>> rtl/pls_if.sv
interface pls_cmd_if import pls_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CMD_W-1:0]           command;
  logic signed [VALUE_W-1:0]  value;
  logic [POS_W-1:0]           position;

  modport source (output valid, command, value, position, input ready);
  modport sink (input valid, command, value, position, output ready);
endinterface

interface pls_rsp_if import pls_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic [FOUND_W-1:0]         found_index;
  logic signed [RDVAL_W-1:0]  read_value;
  logic [COUNT_W-1:0]         entry_count;

  modport source (output valid, status, found_index, read_value, entry_count, input ready);
  modport sink (input valid, status, found_index, read_value, entry_count, output ready);
endinterface

>>> rtl/pls_cmp.sv
module pls_cmp import pls_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic signed [DATA_WIDTH-1:0] a_i,
  input  logic signed [DATA_WIDTH-1:0] b_i,
  output cmp_res_t                     res_o
);

  assign res_o.eq = (a_i == b_i);
  assign res_o.gt = (a_i > b_i);

endmodule

>>> rtl/pls_mem.sv
module pls_mem #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned DATA_WIDTH = 32,
  localparam int unsigned IDX_W     = $clog2(ENTRIES)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [IDX_W-1:0]      waddr_i,
  input  logic [DATA_WIDTH-1:0] wdata_i,
  input  logic [IDX_W-1:0]      raddr_i,
  output logic [DATA_WIDTH-1:0] rdata_o
);

  logic [DATA_WIDTH-1:0] mem_q [ENTRIES];
  logic [DATA_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/pls_seq.sv
module pls_seq import pls_pkg::*; #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned DATA_WIDTH = 32,
  localparam int unsigned IDX_W     = $clog2(ENTRIES),
  localparam int unsigned CNT_W     = $clog2(ENTRIES + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  output logic                         cmd_ready_o,
  input  logic [CMD_W-1:0]             cmd_command_i,
  input  logic signed [VALUE_W-1:0]    cmd_value_i,
  input  logic [POS_W-1:0]             cmd_position_i,
  output logic                         res_valid_o,
  output res_t                         res_o,
  input  logic                         res_free_i,
  output logic                         mem_we_o,
  output logic [IDX_W-1:0]             mem_waddr_o,
  output logic [DATA_WIDTH-1:0]        mem_wdata_o,
  output logic [IDX_W-1:0]             mem_raddr_o,
  input  logic [DATA_WIDTH-1:0]        mem_rdata_i,
  output logic signed [DATA_WIDTH-1:0] cmp_a_o,
  output logic signed [DATA_WIDTH-1:0] cmp_b_o,
  input  cmp_res_t                     cmp_i
);

  localparam int unsigned CW = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  state_e                       state_q, state_d;
  logic [CMD_W-1:0]             cmd_q, cmd_d;
  logic signed [DATA_WIDTH-1:0] val_q, val_d;
  logic [POS_W-1:0]             pos_q, pos_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic [IDX_W-1:0]             ptr_q, ptr_d;
  logic [IDX_W-1:0]             tgt_q, tgt_d;
  logic [IDX_W-1:0]             bound_q, bound_d;
  logic [DATA_WIDTH-1:0]        carry_q, carry_d;
  logic                         phase_q, phase_d;
  status_e                      status_q, status_d;
  logic [FOUND_W-1:0]           found_q, found_d;
  logic [RDVAL_W-1:0]           rdval_q, rdval_d;

  logic [CW-1:0]    pos_x, cnt_x;
  logic             pos_bad_ins, pos_bad, is_full, is_empty, is_one;
  logic [IDX_W-1:0] pos_idx, last_idx, cnt_idx, ins_idx, del_idx, ptr_nxt, ptr_prv;
  logic [CNT_W-1:0] ptr_cnt;

  assign pos_x       = CW'(pos_q);
  assign cnt_x       = CW'(cnt_q);
  assign pos_bad_ins = (pos_q == '0) || (pos_x > (cnt_x + CW'(1)));
  assign pos_bad     = (pos_q == '0) || (pos_x > cnt_x);
  assign is_full     = (cnt_q == CNT_W'(ENTRIES));
  assign is_empty    = (cnt_q == '0);
  assign is_one      = (cnt_q == CNT_W'(1));
  assign pos_idx     = IDX_W'(pos_q - POS_W'(1));
  assign last_idx    = IDX_W'(cnt_q - CNT_W'(1));
  assign cnt_idx     = IDX_W'(cnt_q);
  assign ptr_nxt     = ptr_q + IDX_W'(1);
  assign ptr_prv     = ptr_q - IDX_W'(1);
  assign ptr_cnt     = CNT_W'(ptr_q) + CNT_W'(1);

  always_comb begin
    case (cmd_q)
      CMD_INS_FIRST: ins_idx = '0;
      CMD_INS_LAST:  ins_idx = cnt_idx;
      default:       ins_idx = pos_idx;
    endcase
    case (cmd_q)
      CMD_DEL_FIRST: del_idx = '0;
      CMD_DEL_LAST:  del_idx = last_idx;
      default:       del_idx = pos_idx;
    endcase
  end

  // One comparator serves both search (entry vs. key) and sort (carried vs. entry).
  assign cmp_a_o = (state_q == S_SORT_STEP) ? signed'(carry_q) : signed'(mem_rdata_i);
  assign cmp_b_o = (state_q == S_SORT_STEP) ? signed'(mem_rdata_i) : val_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        case (cmd_q)
          CMD_INS_FIRST, CMD_INS_LAST, CMD_INS_AT: begin
            if (((cmd_q == CMD_INS_AT) && pos_bad_ins) || is_full) state_d = S_DONE;
            else if (ins_idx == cnt_idx) state_d = S_PUT;
            else state_d = S_SHIFT_UP;
          end
          CMD_DEL_FIRST, CMD_DEL_LAST: begin
            if (is_empty || (del_idx == last_idx)) state_d = S_DONE;
            else state_d = S_SHIFT_DN;
          end
          CMD_DEL_AT: begin
            if (pos_bad || (del_idx == last_idx)) state_d = S_DONE;
            else state_d = S_SHIFT_DN;
          end
          CMD_SEARCH: begin
            state_d = is_empty ? S_DONE : S_SEARCH;
          end
          CMD_SORT: begin
            state_d = (is_empty || is_one) ? S_DONE : S_SORT_LOAD;
          end
          CMD_READ_AT: begin
            state_d = pos_bad ? S_DONE : S_READ;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_SHIFT_UP: begin
        if (phase_q && (ptr_q == tgt_q)) state_d = S_PUT;
      end
      S_PUT: state_d = S_DONE;
      S_SHIFT_DN: begin
        if (phase_q && (ptr_nxt == last_idx)) state_d = S_DONE;
      end
      S_SEARCH: begin
        if (phase_q && (cmp_i.eq || (ptr_q == last_idx))) state_d = S_DONE;
      end
      S_READ: begin
        if (phase_q) state_d = S_DONE;
      end
      S_SORT_LOAD: begin
        if (phase_q) state_d = S_SORT_STEP;
      end
      S_SORT_STEP: begin
        if (phase_q && (ptr_q == bound_q)) state_d = S_SORT_END;
      end
      S_SORT_END: begin
        state_d = (bound_q == IDX_W'(1)) ? S_DONE : S_SORT_LOAD;
      end
      S_DONE: begin
        if (res_free_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    cmd_d       = cmd_q;
    val_d       = val_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    tgt_d       = tgt_q;
    bound_d     = bound_q;
    carry_d     = carry_q;
    phase_d     = 1'b0;
    status_d    = status_q;
    found_d     = found_q;
    rdval_d     = rdval_q;
    cmd_ready_o = 1'b0;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = ptr_q;
    mem_wdata_o = mem_rdata_i;
    mem_raddr_o = ptr_q;

    case (state_q)
      S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_d = cmd_command_i;
          val_d = DATA_WIDTH'(cmd_value_i);
          pos_d = cmd_position_i;
        end
      end
      S_DECODE: begin
        status_d = ST_OK;
        found_d  = '0;
        rdval_d  = '0;
        case (cmd_q)
          CMD_INS_FIRST, CMD_INS_LAST, CMD_INS_AT: begin
            tgt_d = ins_idx;
            ptr_d = last_idx;
            if ((cmd_q == CMD_INS_AT) && pos_bad_ins) status_d = ST_BADPOS;
            else if (is_full) status_d = ST_FULL;
          end
          CMD_DEL_FIRST, CMD_DEL_LAST, CMD_DEL_AT: begin
            ptr_d = del_idx;
            if ((cmd_q == CMD_DEL_AT) && pos_bad) status_d = ST_BADPOS;
            else if (is_empty) status_d = ST_EMPTY;
            else if (del_idx == last_idx) cnt_d = cnt_q - CNT_W'(1);
          end
          CMD_SEARCH: begin
            ptr_d = '0;
            if (is_empty) status_d = ST_EMPTY;
          end
          CMD_SORT: begin
            bound_d = last_idx;
            if (is_empty) status_d = ST_EMPTY;
          end
          CMD_READ_AT: begin
            ptr_d = pos_idx;
            if (pos_bad) status_d = ST_BADPOS;
          end
          default: status_d = ST_OK;
        endcase
      end
      S_SHIFT_UP: begin
        // move one entry up a place, walking down toward the gap
        phase_d = !phase_q;
        if (phase_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = ptr_nxt;
          if (ptr_q != tgt_q) ptr_d = ptr_prv;
        end
      end
      S_PUT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = tgt_q;
        mem_wdata_o = val_q;
        cnt_d       = cnt_q + CNT_W'(1);
      end
      S_SHIFT_DN: begin
        // close the gap: read the entry above, write it one place down
        phase_d     = !phase_q;
        mem_raddr_o = ptr_nxt;
        if (phase_q) begin
          mem_we_o = 1'b1;
          if (ptr_nxt == last_idx) cnt_d = cnt_q - CNT_W'(1);
          else ptr_d = ptr_nxt;
        end
      end
      S_SEARCH: begin
        phase_d = !phase_q;
        if (phase_q) begin
          if (cmp_i.eq) found_d = FOUND_W'(ptr_cnt);
          else if (ptr_q == last_idx) status_d = ST_NOTFOUND;
          else ptr_d = ptr_nxt;
        end
      end
      S_READ: begin
        phase_d = !phase_q;
        if (phase_q) rdval_d = RDVAL_W'(signed'(mem_rdata_i));
      end
      S_SORT_LOAD: begin
        phase_d     = !phase_q;
        mem_raddr_o = '0;
        if (phase_q) begin
          carry_d = mem_rdata_i;
          ptr_d   = IDX_W'(1);
          phase_d = 1'b0;
        end
      end
      S_SORT_STEP: begin
        // carry the larger word forward, drop the smaller one behind it
        phase_d = !phase_q;
        if (phase_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = ptr_prv;
          if (cmp_i.gt) begin
            mem_wdata_o = mem_rdata_i;
          end else begin
            mem_wdata_o = carry_q;
            carry_d     = mem_rdata_i;
          end
          if (ptr_q != bound_q) ptr_d = ptr_nxt;
        end
      end
      S_SORT_END: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = bound_q;
        mem_wdata_o = carry_q;
        bound_d     = bound_q - IDX_W'(1);
      end
      S_DONE: begin
        res_valid_o = 1'b1;
      end
      default: begin
        cmd_ready_o = 1'b0;
      end
    endcase
  end

  assign res_o.status      = status_q;
  assign res_o.found_index = found_q;
  assign res_o.read_value  = rdval_q;
  assign res_o.entry_count = COUNT_W'(cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    val_q    <= val_d;
    pos_q    <= pos_d;
    ptr_q    <= ptr_d;
    tgt_q    <= tgt_d;
    bound_q  <= bound_d;
    carry_q  <= carry_d;
    status_q <= status_d;
    found_q  <= found_d;
    rdval_q  <= rdval_d;
  end

endmodule

>>> rtl/positional_list_store.sv
// Bounded ordered list of signed words driven by one command per word on cmd_i
// (insert first/last/at, delete first/last/at, search, stable ascending sort,
// read at a 1-based position); each command returns one word on rsp_o with a
// status, the match index, the read value and the entry count after the command.
// Entries sit in a single-port-read memory of ENTRIES words, and one shared
// comparator walks it under a small sequencer, so the block takes one command at
// a time and every touched entry is read, then written or compared. A command
// refused by its checks or an unused code goes straight to its result; an insert
// or delete moves the entries past its position, a search stops at the first
// match, and a sort makes repeated passes over a shrinking range of entries.
// A finished result waits in the output register while the next command is
// accepted.
module positional_list_store import pls_pkg::*; #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  pls_cmd_if.sink   cmd_i,
  pls_rsp_if.source rsp_o
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);

  logic                         res_valid, res_free;
  res_t                         res;
  logic                         mem_we;
  logic [IDX_W-1:0]             mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0]        mem_wdata, mem_rdata;
  logic signed [DATA_WIDTH-1:0] cmp_a, cmp_b;
  cmp_res_t                     cmp_res;
  logic                         rsp_valid_q, rsp_valid_d;
  res_t                         rsp_q, rsp_d;

  pls_seq #(
    .ENTRIES    (ENTRIES),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_i.valid),
    .cmd_ready_o    (cmd_i.ready),
    .cmd_command_i  (cmd_i.command),
    .cmd_value_i    (cmd_i.value),
    .cmd_position_i (cmd_i.position),
    .res_valid_o    (res_valid),
    .res_o          (res),
    .res_free_i     (res_free),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata),
    .cmp_a_o        (cmp_a),
    .cmp_b_o        (cmp_b),
    .cmp_i          (cmp_res)
  );

  pls_mem #(
    .ENTRIES    (ENTRIES),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  pls_cmp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_cmp (
    .a_i   (cmp_a),
    .b_i   (cmp_b),
    .res_o (cmp_res)
  );

  // Output register: free when empty or being drained this cycle.
  assign res_free = !rsp_valid_q || rsp_o.ready;

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    rsp_d       = rsp_q;
    if (res_valid && res_free) begin
      rsp_valid_d = 1'b1;
      rsp_d       = res;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_q.status;
  assign rsp_o.found_index = rsp_q.found_index;
  assign rsp_o.read_value  = rsp_q.read_value;
  assign rsp_o.entry_count = rsp_q.entry_count;

endmodule

>>> rtl/pls_chk.sv
`include "assert_macros.svh"

module pls_chk import pls_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cmd_valid_i,
  input logic                cmd_ready_i,
  input logic                rsp_valid_i,
  input logic                rsp_ready_i,
  input logic [STATUS_W-1:0] rsp_status_i,
  input logic [FOUND_W-1:0]  rsp_found_index_i,
  input logic [RDVAL_W-1:0]  rsp_read_value_i,
  input logic [COUNT_W-1:0]  rsp_entry_count_i
);

  `ASSERT_DFLT(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i, "response dropped while stalled")

  `ASSERT_DFLT(a_rsp_stable, rsp_valid_i && !rsp_ready_i |=> $stable(rsp_status_i) && $stable(rsp_found_index_i) && $stable(rsp_read_value_i) && $stable(rsp_entry_count_i), "response changed while stalled")

  `ASSERT_DFLT(a_busy_after_accept, cmd_valid_i && cmd_ready_i |=> !cmd_ready_i, "command taken while busy")

  `ASSERT_DFLT(a_found_ok, rsp_valid_i && (rsp_found_index_i != '0) |-> rsp_status_i == ST_OK, "match index with error status")

  `ASSERT_DFLT(a_read_ok, rsp_valid_i && (rsp_read_value_i != '0) |-> rsp_status_i == ST_OK, "read value with error status")

endmodule

bind positional_list_store pls_chk u_pls_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .cmd_valid_i       (cmd_i.valid),
  .cmd_ready_i       (cmd_i.ready),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_status_i      (rsp_o.status),
  .rsp_found_index_i (rsp_o.found_index),
  .rsp_read_value_i  (rsp_o.read_value),
  .rsp_entry_count_i (rsp_o.entry_count)
);

>>> bench/tb_positional_list_store.sv
`timescale 1ns / 1ps

module tb_positional_list_store;
  import pls_pkg::*;

  localparam int unsigned LIST_DEPTH     = 16;
  localparam int unsigned TOTAL_ITEMS    = 1900;
  localparam int unsigned HOLD_AT        = 300;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned DRAIN_CYCLES   = 320;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned MAX_REPORTS    = 10;

  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = CMD_W'(CMD_READ_AT + 1);
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = '1;

  typedef enum int {SEQ_GROW, SEQ_SHRINK, SEQ_QUERY, SEQ_NOISE} seq_kind_e;

  // Mirror of the list contents plus the queue of result words still owed.
  class list_store_sb;
    logic signed [VALUE_W-1:0] entries [LIST_DEPTH];
    int unsigned count = 0;
    res_t owed_q[$];
    int unsigned errors = 0;

    function void remove_at(int unsigned idx);
      int unsigned i;
      for (i = idx; i + 1 < count; i++) entries[i] = entries[i + 1];
      count--;
    endfunction

    function void note_command(logic [CMD_W-1:0] c, logic signed [VALUE_W-1:0] v,
                               logic [POS_W-1:0] p);
      res_t r;
      int unsigned i, j, idx;
      logic signed [VALUE_W-1:0] t;
      r = '0;
      r.status = ST_OK;
      case (c)
        CMD_INS_FIRST, CMD_INS_LAST, CMD_INS_AT: begin
          if (c == CMD_INS_AT && (p == 0 || p > count + 1)) begin
            r.status = ST_BADPOS;
          end else if (count >= LIST_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            idx = (c == CMD_INS_FIRST) ? 0 : (c == CMD_INS_LAST) ? count : p - 1;
            for (i = count; i > idx; i--) entries[i] = entries[i - 1];
            entries[idx] = v;
            count++;
          end
        end
        CMD_DEL_FIRST, CMD_DEL_LAST: begin
          if (count == 0) r.status = ST_EMPTY;
          else remove_at((c == CMD_DEL_FIRST) ? 0 : count - 1);
        end
        CMD_DEL_AT: begin
          if (p == 0 || p > count) r.status = ST_BADPOS;
          else remove_at(p - 1);
        end
        CMD_SEARCH: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.status = ST_NOTFOUND;
            for (i = 0; i < count; i++) begin
              if (r.status == ST_NOTFOUND && entries[i] == v) begin
                r.status = ST_OK;
                r.found_index = FOUND_W'(i + 1);
              end
            end
          end
        end
        CMD_SORT: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            // bubble passes swap only on strictly greater, so ties keep their order
            for (i = count; i > 1; i--) begin
              for (j = 0; j + 1 < i; j++) begin
                if (entries[j] > entries[j + 1]) begin
                  t = entries[j];
                  entries[j] = entries[j + 1];
                  entries[j + 1] = t;
                end
              end
            end
          end
        end
        CMD_READ_AT: begin
          if (p == 0 || p > count) r.status = ST_BADPOS;
          else r.read_value = entries[p - 1];
        end
        default: ;
      endcase
      r.entry_count = COUNT_W'(count);
      owed_q.push_back(r);
    endfunction

    function void check_response(logic [STATUS_W-1:0] st, logic [FOUND_W-1:0] fi,
                                 logic signed [RDVAL_W-1:0] rv, logic [COUNT_W-1:0] ec);
      res_t e;
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result word: status=%0d found=%0d read=%0d count=%0d",
                   st, fi, rv, ec);
        return;
      end
      e = owed_q.pop_front();
      if (st !== e.status || fi !== e.found_index || rv !== e.read_value ||
          ec !== e.entry_count) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("mismatch: expected status=%0d found=%0d read=%0d count=%0d,",
                   e.status, e.found_index, $signed(e.read_value), e.entry_count,
                   " got status=%0d found=%0d read=%0d count=%0d",
                   st, fi, rv, ec);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  pls_cmd_if cmd_if ();
  pls_rsp_if rsp_if ();

  positional_list_store #(
    .ENTRIES    (LIST_DEPTH),
    .DATA_WIDTH (VALUE_W)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .rsp_o  (rsp_if)
  );

  list_store_sb sb = new();
  int unsigned sent_count = 0;
  int unsigned rsp_count = 0;
  int unsigned quiet_cycles = 0;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic signed [VALUE_W-1:0] pick_value();
    int d;
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3, 4: begin
        // small range so that searches hit and sorts see ties
        d = int'($urandom_range(0, 6)) - 3;
        return d;
      end
      default: return $urandom;
    endcase
  endfunction

  // Mostly a legal position in 1..hi, now and then just outside or anywhere.
  function automatic logic [POS_W-1:0] pick_pos(int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 19);
    if (hi == 0 || r == 0) return POS_W'($urandom_range(0, 255));
    if (r == 1) return '0;
    if (r == 2) return POS_W'(hi + 1);
    return POS_W'($urandom_range(1, hi));
  endfunction

  // Starts and ends at a falling edge; valid stays high across back-to-back words.
  task automatic send_word(input logic [CMD_W-1:0] c, input logic signed [VALUE_W-1:0] v,
                           input logic [POS_W-1:0] p);
    int unsigned gap;
    gap = (sent_count % 256 < 40) ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_if.valid    <= 1'b1;
    cmd_if.command  <= c;
    cmd_if.value    <= v;
    cmd_if.position <= p;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    sb.note_command(c, v, p);
    sent_count++;
    @(negedge clk_i);
  endtask

  task automatic send_random(input seq_kind_e kind);
    logic [CMD_W-1:0] c;
    logic signed [VALUE_W-1:0] v;
    logic [POS_W-1:0] p;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    v = pick_value();
    p = pick_pos(sb.count);
    case (kind)
      SEQ_GROW: begin
        if (roll < 30) c = CMD_INS_FIRST;
        else if (roll < 60) c = CMD_INS_LAST;
        else if (roll < 90) begin
          c = CMD_INS_AT;
          p = pick_pos(sb.count + 1);
        end else c = CMD_SEARCH;
      end
      SEQ_SHRINK: begin
        if (roll < 30) c = CMD_DEL_FIRST;
        else if (roll < 60) c = CMD_DEL_LAST;
        else if (roll < 95) c = CMD_DEL_AT;
        else c = CMD_READ_AT;
      end
      SEQ_QUERY: begin
        if (roll < 50) c = CMD_SEARCH;
        else if (roll < 90) c = CMD_READ_AT;
        else c = CMD_SORT;
      end
      default: begin
        c = CMD_W'($urandom_range(0, 15));
        v = $urandom;
        p = POS_W'($urandom_range(0, 255));
      end
    endcase
    if (c == CMD_SEARCH && sb.count > 0 && roll[0])
      v = sb.entries[$urandom_range(0, sb.count - 1)];
    send_word(c, v, p);
  endtask

  task automatic run_directed();
    send_word(CMD_SEARCH, 0, 0);
    send_word(CMD_SORT, 0, 0);
    send_word(CMD_DEL_FIRST, 0, 0);
    send_word(CMD_DEL_LAST, 0, 0);
    send_word(CMD_DEL_AT, 0, 1);
    send_word(CMD_READ_AT, 0, 1);
    send_word(CMD_INS_AT, 1, 0);
    send_word(CMD_INS_AT, 1, 2);
    send_word(CMD_INS_FIRST, 32'h7FFF_FFFF, 0);
    send_word(CMD_INS_LAST, 32'h8000_0000, 0);
    send_word(CMD_INS_AT, -1, 3);
    send_word(CMD_INS_AT, 0, 1);
    send_word(CMD_INS_AT, 5, 2);
    send_word(CMD_INS_LAST, 5, 255);
    send_word(CMD_SEARCH, 5, 0);
    send_word(CMD_SEARCH, 1234, 0);
    send_word(CMD_READ_AT, 0, 1);
    send_word(CMD_READ_AT, 0, 6);
    send_word(CMD_READ_AT, 0, 7);
    send_word(CMD_READ_AT, 0, 255);
    send_word(CMD_SORT, 0, 0);
    send_word(CMD_READ_AT, 0, 1);
    send_word(CMD_DEL_AT, 0, 255);
    send_word(CMD_DEL_AT, 0, 3);
    send_word(CMD_DEL_FIRST, 0, 0);
    send_word(CMD_DEL_LAST, 0, 0);
    send_word(CMD_UNUSED_LO, 32'hFFFF_FFFF, 8'hFF);
    send_word(CMD_UNUSED_HI, 0, 0);
  endtask

  task automatic run_random();
    seq_kind_e kind;
    int unsigned len, roll;
    bit drained;
    drained = 1'b0;
    while (sent_count < TOTAL_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 30) kind = SEQ_GROW;
      else if (roll < 55) kind = SEQ_SHRINK;
      else if (roll < 80) kind = SEQ_QUERY;
      else kind = SEQ_NOISE;
      len = $urandom_range(3, 24);
      repeat (len) send_random(kind);
      if (!drained && sent_count >= TOTAL_ITEMS / 2) begin
        // hold the input until every owed word is back
        drained = 1'b1;
        cmd_if.valid <= 1'b0;
        @(negedge clk_i);
        while (sb.owed_q.size() != 0) @(negedge clk_i);
      end
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    cmd_if.valid    = 1'b0;
    cmd_if.command  = '0;
    cmd_if.value    = '0;
    cmd_if.position = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    run_directed();
    run_random();
    cmd_if.valid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    bit held;
    held = 1'b0;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && rsp_count == HOLD_AT) begin
        // long hold-off: let the block back up and stall its input
        held = 1'b1;
        stall = HOLD_CYCLES;
      end else begin
        stall = (rsp_count % 200 < 30) ? 0 : $urandom_range(0, 7);
      end
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_if.valid) @(posedge clk_i);
      sb.check_response(rsp_if.status, rsp_if.found_index, rsp_if.read_value,
                        rsp_if.entry_count);
      rsp_count++;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
